// ----- design/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// shared types, constants and the crc-16 byte update for the frame deframer
// ----------------------------------------------------------------------------
package fdc_pkg;

    localparam int MAX_PAYLOAD = 1024;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_GOOD      = 2'd1,
        KIND_BAD_CRC   = 2'd2,
        KIND_LINK_LOST = 2'd3
    } kind_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  frame_kind;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_offset;
        logic [10:0] frame_length;
        logic        frame_last;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] idle_timeout;
    } cfg_t;

    // msb-first crc-16, one byte, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- design/fdc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fdc_cfg_regs
// software-visible sync bytes and idle timeout
// ----------------------------------------------------------------------------
module fdc_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [fdc_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [31:0]                      wr_data,
    output fdc_pkg::cfg_t                    cfg
);

    fdc_pkg::cfg_t cfg_reg;
    fdc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                fdc_pkg::CFG_SYNC_FIRST:   cfg_next.sync_first = wr_data[7:0];
                fdc_pkg::CFG_SYNC_SECOND:  cfg_next.sync_second = wr_data[7:0];
                fdc_pkg::CFG_IDLE_TIMEOUT: cfg_next.idle_timeout = wr_data[15:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first   <= 8'd0;
            cfg_reg.sync_second  <= 8'd0;
            cfg_reg.idle_timeout <= fdc_pkg::TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/fdc_parser.sv -----
// ----------------------------------------------------------------------------
// fdc_parser
// frame parse state, running crc and idle counter; one word per enabled cycle
// ----------------------------------------------------------------------------
module fdc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  fdc_pkg::cfg_t       cfg,
    input  logic                step,
    input  fdc_pkg::in_item_t   item,
    output logic                res_valid,
    output fdc_pkg::out_item_t  res_item
);

    typedef enum logic [2:0] {
        PH_SYNC1, PH_SYNC2, PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] length_reg, length_next;
    logic [10:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_high_reg, crc_high_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [15:0] ticks_inc;
    logic [15:0] crc_upd;
    logic [15:0] full_length;
    logic [10:0] count_inc;
    logic [7:0]  b;

    assign b = item.rx_byte;
    assign ticks_inc = (ticks_reg < fdc_pkg::TICKS_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    // type byte restarts the crc
    assign crc_upd = fdc_pkg::crc_feed((phase_reg == PH_TYPE) ? fdc_pkg::CRC_INIT : crc_reg, b);
    assign full_length = {b, length_reg[7:0]};
    assign count_inc = count_reg + 11'd1;

    always_comb begin
        phase_next    = phase_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_high_next = crc_high_reg;
        ticks_next    = ticks_reg;
        res_valid     = 1'b0;
        res_item      = '0;

        if (step) begin
            if (item.op == fdc_pkg::OP_TICK) begin
                if (ticks_inc > cfg.idle_timeout) begin
                    ticks_next    = 16'd0;
                    res_valid     = 1'b1;
                    res_item.kind = fdc_pkg::KIND_LINK_LOST;
                end else begin
                    ticks_next = ticks_inc;
                end
            end else begin
                ticks_next = 16'd0;
                unique case (phase_reg)
                    PH_SYNC1: begin
                        if (b == cfg.sync_first) begin
                            phase_next = PH_SYNC2;
                        end
                    end
                    PH_SYNC2: begin
                        phase_next = (b == cfg.sync_second) ? PH_TYPE : PH_SYNC1;
                    end
                    PH_TYPE: begin
                        type_next  = b;
                        crc_next   = crc_upd;
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        length_next = {8'd0, b};
                        crc_next    = crc_upd;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        length_next = full_length;
                        crc_next    = crc_upd;
                        if (32'(full_length) > 32'(fdc_pkg::MAX_PAYLOAD)) begin
                            phase_next = PH_SYNC1;
                        end else begin
                            count_next = 11'd0;
                            phase_next = (full_length == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        crc_next   = crc_upd;
                        count_next = count_inc;
                        if (16'(count_inc) >= length_reg) begin
                            phase_next = PH_CRC_HI;
                        end
                        res_valid             = 1'b1;
                        res_item.kind         = fdc_pkg::KIND_PAYLOAD;
                        res_item.frame_kind   = type_reg;
                        res_item.payload_byte = b;
                        res_item.byte_offset  = count_reg[9:0];
                        res_item.frame_length = length_reg[10:0];
                    end
                    PH_CRC_HI: begin
                        crc_high_next = b;
                        phase_next    = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        phase_next            = PH_SYNC1;
                        res_valid             = 1'b1;
                        res_item.kind         = ({crc_high_reg, b} == crc_reg) ?
                                                fdc_pkg::KIND_GOOD : fdc_pkg::KIND_BAD_CRC;
                        res_item.frame_kind   = type_reg;
                        res_item.frame_length = length_reg[10:0];
                        res_item.frame_last   = 1'b1;
                    end
                    default: phase_next = PH_SYNC1;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC1;
            type_reg     <= 8'd0;
            length_reg   <= 16'd0;
            count_reg    <= 11'd0;
            crc_reg      <= fdc_pkg::CRC_INIT;
            crc_high_reg <= 8'd0;
            ticks_reg    <= 16'd0;
        end else begin
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            crc_high_reg <= crc_high_next;
            ticks_reg    <= ticks_next;
        end
    end

endmodule

// ----- design/frame_deframer_crc16_check.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check
// sync/type/length/payload/crc-16 frame parser with idle link-lost report
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          word
//  s_        in         s_valid/s_ready    op, rx_byte
//  m_        out        m_valid/m_ready    kind, frame_kind, payload_byte,
//                                          byte_offset, frame_length, frame_last
//  cfg_      in         cfg_valid/cfg_ready index 0..2, data
//
//  one word per cycle sustained while m_ready is high: input register, then
//  the parser step (crc byte update, eight shift steps) into the result register
//  an accepted word passes the input register, then the result register, to m_valid
//  a word that makes no result just advances the parser state
//  s_ready follows m_ready combinationally when both registers hold words
//  synchronous active-low reset, no clearing pass; cfg_ready is always high
//
module frame_deframer_crc16_check (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  fdc_pkg::in_item_t                s_item,

    output logic                             m_valid,
    input  logic                             m_ready,
    output fdc_pkg::out_item_t               m_item,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fdc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data
);

    fdc_pkg::cfg_t      cfg;

    // input register
    logic               in_valid_reg, in_valid_next;
    fdc_pkg::in_item_t  in_item_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    fdc_pkg::out_item_t out_item_reg;

    logic               advance;
    logic               res_valid;
    fdc_pkg::out_item_t res_item;

    assign cfg_ready = 1'b1;

    fdc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // the held word moves through the parser when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    fdc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance && res_valid) begin
            out_item_reg <= res_item;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

// ----- sim/frame_deframer_crc16_check_tb.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check_tb
// self-checking bench: byte and tick words go in, every result word is
// compared against an in-bench deframer with its own crc-16 and idle counter
// ----------------------------------------------------------------------------
module frame_deframer_crc16_check_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // register index past the end of the list, the block must ignore it
    localparam logic [fdc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    // cycles with no word moving on any channel before the run is abandoned
    localparam int STALL_LIMIT = 1000;
    // cycles the final drain may take before leftovers count as missing
    localparam int DRAIN_LIMIT = 500;
    // a word that makes no result may still be in the two-stage pipe
    localparam int PIPE_FLUSH = 4;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } parse_phase_t;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    always #1 aclk = ~aclk;

    // block ports, every input known from time zero
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    fdc_pkg::in_item_t               s_item = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    fdc_pkg::out_item_t              m_item;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [fdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                     cfg_data = '0;

    frame_deframer_crc16_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // in-bench deframer state, mirrors the block register for register
    fdc_pkg::cfg_t model_cfg;
    parse_phase_t  rx_phase;
    logic [7:0]    cur_type;
    logic [15:0]   decl_len;
    logic [15:0]   rcv_count;
    logic [15:0]   run_crc;
    logic [7:0]    crc_hi;
    logic [15:0]   idle_ticks;

    // result words the block still owes, oldest first
    fdc_pkg::out_item_t expected_reports[$];
    fdc_pkg::out_item_t want;

    // run bookkeeping
    int unsigned error_count = 0;
    int unsigned words_sent = 0;
    int unsigned reg_writes = 0;
    int unsigned reports_seen [4];
    int unsigned quiet_cycles = 0;
    int          stall_left = 0;
    bit          idling = 1'b1;
    int unsigned tick_odds = 0;

    // crc-16/ccitt-false, one input bit per step, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ fdc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic fdc_pkg::out_item_t make_report(input fdc_pkg::kind_t k,
                                                       input logic [7:0] fk,
                                                       input logic [7:0] pb,
                                                       input logic [9:0] off,
                                                       input logic [10:0] len,
                                                       input logic last);
        fdc_pkg::out_item_t r;
        r.kind         = k;
        r.frame_kind   = fk;
        r.payload_byte = pb;
        r.byte_offset  = off;
        r.frame_length = len;
        r.frame_last   = last;
        return r;
    endfunction

    // one accepted word through the deframer, queues the result it causes
    function automatic void deframe_step(input fdc_pkg::in_item_t w);
        logic [7:0]  b;
        logic [15:0] crc_rx;
        b = w.rx_byte;
        if (w.op == fdc_pkg::OP_TICK) begin
            // idle counter pins at its max and restarts after a link-lost report
            if (idle_ticks != fdc_pkg::TICKS_MAX) begin
                idle_ticks = idle_ticks + 16'd1;
            end
            if (idle_ticks > model_cfg.idle_timeout) begin
                idle_ticks = '0;
                expected_reports.push_back(make_report(fdc_pkg::KIND_LINK_LOST, 8'h00, 8'h00,
                                                       10'd0, 11'd0, 1'b0));
            end
        end else begin
            idle_ticks = '0;
            case (rx_phase)
                PH_SYNC1: begin
                    if (b == model_cfg.sync_first) begin
                        rx_phase = PH_SYNC2;
                    end
                end
                // a wrong second sync byte is not looked at again as a first one
                PH_SYNC2: begin
                    rx_phase = (b == model_cfg.sync_second) ? PH_TYPE : PH_SYNC1;
                end
                PH_TYPE: begin
                    cur_type = b;
                    run_crc  = crc16_byte(fdc_pkg::CRC_INIT, b);
                    rx_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    decl_len = {8'h00, b};
                    run_crc  = crc16_byte(run_crc, b);
                    rx_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    decl_len[15:8] = b;
                    run_crc = crc16_byte(run_crc, b);
                    // oversize header drops the frame without a report
                    if (decl_len > fdc_pkg::MAX_PAYLOAD) begin
                        rx_phase = PH_SYNC1;
                    end else begin
                        rcv_count = '0;
                        rx_phase  = (decl_len == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    expected_reports.push_back(make_report(fdc_pkg::KIND_PAYLOAD, cur_type, b,
                                                           rcv_count[9:0], decl_len[10:0],
                                                           1'b0));
                    run_crc   = crc16_byte(run_crc, b);
                    rcv_count = rcv_count + 16'd1;
                    if (rcv_count >= decl_len) begin
                        rx_phase = PH_CRC_HI;
                    end
                end
                PH_CRC_HI: begin
                    crc_hi   = b;
                    rx_phase = PH_CRC_LO;
                end
                default: begin
                    crc_rx = {crc_hi, b};
                    expected_reports.push_back(make_report(
                        (crc_rx == run_crc) ? fdc_pkg::KIND_GOOD : fdc_pkg::KIND_BAD_CRC,
                        cur_type, 8'h00, 10'd0, decl_len[10:0], 1'b1));
                    rx_phase = PH_SYNC1;
                end
            endcase
        end
    endfunction

    task automatic flag_error(input string what, input int unsigned got,
                              input int unsigned exp_v);
        $display("ERROR at %0t: %s, got 0x%0h expected 0x%0h", $realtime, what, got, exp_v);
        error_count++;
    endtask

    // one input word: optional idle burst, then hold valid until it is taken
    task automatic send_word(input fdc_pkg::in_item_t w);
        if (idling && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        deframe_step(w);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_word('{op: fdc_pkg::OP_BYTE, rx_byte: b});
    endtask

    // tick words carry random junk in the byte field
    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word('{op: fdc_pkg::OP_TICK, rx_byte: 8'($urandom)});
    endtask

    // full frame with the current sync pair; oversize headers get up to six junk
    // bytes instead of a body, and ticks may be sprinkled between the bytes
    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                              input bit corrupt);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        int          body;
        bytes = '{model_cfg.sync_first, model_cfg.sync_second, ftype, len[7:0], len[15:8]};
        crc = crc16_byte(fdc_pkg::CRC_INIT, ftype);
        crc = crc16_byte(crc, len[7:0]);
        crc = crc16_byte(crc, len[15:8]);
        body = (len > fdc_pkg::MAX_PAYLOAD) ? int'($urandom_range(0, 6)) : int'(len);
        for (int i = 0; i < body; i++) begin
            bytes.push_back(8'($urandom));
            crc = crc16_byte(crc, bytes[bytes.size()-1]);
        end
        if (len <= fdc_pkg::MAX_PAYLOAD) begin
            if (corrupt) begin
                crc = crc ^ (16'd1 << $urandom_range(0, 15));
            end
            bytes.push_back(crc[15:8]);
            bytes.push_back(crc[7:0]);
        end
        foreach (bytes[i]) begin
            if (i != 0 && tick_odds != 0 && $urandom_range(1, tick_odds) == 1) begin
                send_ticks($urandom_range(1, 6));
            end
            send_byte(bytes[i]);
        end
    endtask

    // drop valid, let every owed result drain, then flush the pipe
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (PIPE_FLUSH) @(posedge aclk);
    endtask

    // register write, only called once the block has settled
    task automatic write_reg(input logic [fdc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            fdc_pkg::CFG_SYNC_FIRST:   model_cfg.sync_first   = data[7:0];
            fdc_pkg::CFG_SYNC_SECOND:  model_cfg.sync_second  = data[7:0];
            fdc_pkg::CFG_IDLE_TIMEOUT: model_cfg.idle_timeout = data[15:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset sync pair is 00/00; top type value and a one-byte payload
    task automatic test_reset_values();
        send_frame(8'hFF, 16'd1, 1'b0);
    endtask

    // register writes with junk above each width, plus one unused index,
    // then the parser corner cases
    task automatic test_register_writes();
        settle();
        write_reg(fdc_pkg::CFG_SYNC_FIRST, 32'hFFFF_FF5A);
        write_reg(fdc_pkg::CFG_SYNC_SECOND, 32'h0000_01C3);
        write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'hABCD_0002);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        // second sync wrong but equal to the first sync value, must not re-arm
        send_byte(8'h5A);
        send_byte(8'h5A);
        send_byte(8'hC3);
        // zero length, crc right after the header
        send_frame(8'h00, 16'd0, 1'b0);
        // one past the max length, silently dropped
        send_frame(8'h11, 16'd1025, 1'b0);
        send_frame(8'h80, 16'd2, 1'b1);
        // timeout of 2: third idle tick reports link lost
        send_ticks(3);
    endtask

    // timeout 0 reports on every tick, also in the middle of a frame
    task automatic test_zero_timeout();
        settle();
        write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'h0000_0000);
        send_ticks(3);
        tick_odds = 2;
        send_frame(8'h7E, 16'd3, 1'b0);
        tick_odds = 0;
    endtask

    // idle count equal to the timeout gives no report, then a lowered
    // timeout fires on the very next tick
    task automatic test_idle_lowered_timeout();
        settle();
        idling = 1'b0;
        write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'h0000_0014);
        send_ticks(20);
        settle();
        write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'h0000_000A);
        send_ticks(2);
        send_byte(8'h3C);
        idling = 1'b1;
    endtask

    // largest legal payload, then the largest header value
    task automatic test_longest_frame();
        settle();
        write_reg(fdc_pkg::CFG_SYNC_FIRST, 32'h0000_00FF);
        write_reg(fdc_pkg::CFG_SYNC_SECOND, 32'h0000_0000);
        write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'h0000_0004);
        send_frame(8'($urandom), 16'd1024, 1'b0);
        send_frame(8'($urandom), 16'hFFFF, 1'b0);
        send_frame(8'($urandom), 16'd5, 1'b0);
    endtask

    // mostly good frames with random content, mixed with bad crc, oversize
    // headers, broken sync, tick runs and loose bytes, over several settings
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned pick;
        logic [15:0] len;
        bit          paused;
        for (int p = 0; p < 4; p++) begin
            settle();
            case (p)
                0: begin
                    write_reg(fdc_pkg::CFG_SYNC_FIRST, $urandom);
                    write_reg(fdc_pkg::CFG_SYNC_SECOND, $urandom);
                    write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, $urandom_range(1, 6));
                    tick_odds = 8;
                end
                1: begin
                    // equal sync bytes at the top of the range, timeout of 1
                    write_reg(fdc_pkg::CFG_SYNC_FIRST, 32'h0000_00FF);
                    write_reg(fdc_pkg::CFG_SYNC_SECOND, 32'h0000_00FF);
                    write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, 32'h0000_0001);
                    tick_odds = 16;
                end
                2: begin
                    write_reg(fdc_pkg::CFG_SYNC_FIRST, 32'h0000_0000);
                    write_reg(fdc_pkg::CFG_SYNC_SECOND, $urandom);
                    write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, $urandom_range(2, 10));
                    tick_odds = 0;
                end
                default: begin
                    // closing stretch runs at full rate on both sides
                    idling = 1'b0;
                    write_reg(fdc_pkg::CFG_SYNC_FIRST, $urandom);
                    write_reg(fdc_pkg::CFG_SYNC_SECOND, $urandom);
                    write_reg(fdc_pkg::CFG_IDLE_TIMEOUT, $urandom_range(1, 6));
                    tick_odds = 8;
                end
            endcase
            phase_end = words_sent + 55;
            paused = 1'b0;
            while (words_sent < phase_end) begin
                // hold the sender once until the block has caught up
                if (p == 2 && !paused && words_sent > phase_end - 27) begin
                    settle();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 64))
                                                       : 16'($urandom_range(0, 12));
                    send_frame(8'($urandom), len, 1'b0);
                end else if (pick < 78) begin
                    send_frame(8'($urandom), 16'($urandom_range(0, 12)), 1'b1);
                end else if (pick < 83) begin
                    len = ($urandom_range(0, 3) == 0) ?
                          16'hFFFF : 16'($urandom_range(fdc_pkg::MAX_PAYLOAD + 1, 65535));
                    send_frame(8'($urandom), len, 1'b0);
                end else if (pick < 88) begin
                    send_byte(model_cfg.sync_first);
                    send_byte(model_cfg.sync_second ^ 8'($urandom_range(1, 255)));
                end else if (pick < 93) begin
                    send_ticks($urandom_range(1, 12));
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
        end
        tick_odds = 0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall bursts on m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 15) == 0) begin
            // stall burst of random length, including this one
            stall_left <= $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: every accepted result word against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            reports_seen[m_item.kind]++;
            if (expected_reports.size() == 0) begin
                flag_error("result word with nothing owed, kind", m_item.kind, 0);
            end else begin
                want = expected_reports.pop_front();
                if (m_item.kind != want.kind) begin
                    flag_error("kind", m_item.kind, want.kind);
                end
                if (m_item.frame_kind != want.frame_kind) begin
                    flag_error("frame_kind", m_item.frame_kind, want.frame_kind);
                end
                if (m_item.payload_byte != want.payload_byte) begin
                    flag_error("payload_byte", m_item.payload_byte, want.payload_byte);
                end
                if (m_item.byte_offset != want.byte_offset) begin
                    flag_error("byte_offset", m_item.byte_offset, want.byte_offset);
                end
                if (m_item.frame_length != want.frame_length) begin
                    flag_error("frame_length", m_item.frame_length, want.frame_length);
                end
                if (m_item.frame_last != want.frame_last) begin
                    flag_error("frame_last", m_item.frame_last, want.frame_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no word moving anywhere ends the run
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("frame_deframer_crc16_check test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int drain_cycles;

        // deframer state after reset
        model_cfg.sync_first   = 8'h00;
        model_cfg.sync_second  = 8'h00;
        model_cfg.idle_timeout = fdc_pkg::TIMEOUT_RESET;
        rx_phase   = PH_SYNC1;
        cur_type   = '0;
        decl_len   = '0;
        rcv_count  = '0;
        run_crc    = fdc_pkg::CRC_INIT;
        crc_hi     = '0;
        idle_ticks = '0;
        foreach (reports_seen[k]) reports_seen[k] = 0;

        // hold reset, then release it and let the block leave reset before the first test
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_register_writes();
        test_zero_timeout();
        test_idle_lowered_timeout();
        test_longest_frame();
        test_random_traffic();

        // drain with a bound, then give the pipe time to show strays
        s_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_reports.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (PIPE_FLUSH) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            flag_error("result words never delivered, count", expected_reports.size(), 0);
        end

        $display("run: %0d input words, %0d register writes, %0d payload words checked",
                 words_sent, reg_writes, reports_seen[fdc_pkg::KIND_PAYLOAD]);
        $display("run: %0d good frames, %0d bad-crc frames, %0d link-lost reports",
                 reports_seen[fdc_pkg::KIND_GOOD], reports_seen[fdc_pkg::KIND_BAD_CRC],
                 reports_seen[fdc_pkg::KIND_LINK_LOST]);
        if (error_count == 0) begin
            $display("frame_deframer_crc16_check test passed");
        end else begin
            $display("frame_deframer_crc16_check test failed");
        end
        $finish;
    end

endmodule
